[src/qdi_pkg.sv]
// Shared types and constants for the quadrilateral diagonal intersection block.
// No dependencies; imported by the datapath and the port checker.
`default_nettype none

package qdi_pkg;

	localparam int COORD_W = 16;
	localparam int OUT_W   = 18;
	localparam int CX_QW   = 18;

	localparam logic signed [OUT_W-1:0] OUT_MIN = -(OUT_W'(1) <<< (OUT_W - 1));
	localparam logic signed [OUT_W-1:0] OUT_MAX = (OUT_W'(1) <<< (OUT_W - 1)) - OUT_W'(1);

	// Largest magnitudes that still fit after negation or as a positive value.
	localparam logic [CX_QW-1:0] MAG_NEG_MAX = CX_QW'(1) << (OUT_W - 1);
	localparam logic [CX_QW-1:0] MAG_POS_MAX = (CX_QW'(1) << (OUT_W - 1)) - CX_QW'(1);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DUP       = 2'd1,
		ST_BOTH_VERT = 2'd2,
		ST_PARALLEL  = 2'd3
	} status_t;

endpackage

`default_nettype wire

[src/quad_diagonal_intersection.sv]
// Usage
// Corner sets enter on the s_ stream: s_tdata holds eight unsigned 16-bit
// coordinates. Each item yields one result item on the m_ stream with the
// crossing point of diagonals 0-2 and 1-3 as signed integers (Q18.0), saturated, plus a
// status code and a saturation flag in m_tuser.
// The pipeline is made of the pipelined dividers, one stage per quotient
// bit: SLOPE_FRAC_BITS + 16 for the slopes and 18 for the x coordinate,
// plus eight arithmetic stages around them.
// Throughput is one item per cycle while the receiver takes results.
// The whole pipeline advances as one: when m_tvalid is high and m_tready low,
// every stage holds and s_tready drops, so nothing is lost or repeated.
// The output register does not part the two sides: s_tready follows m_tready
// combinationally and is high whenever the last stage is empty or being drained.
// Reset clears all valid bits; no result is shown until an item has passed.
// Depends on qdi_pkg and qdi_div.
`default_nettype none

module quad_diagonal_intersection
	import qdi_pkg::*;
#(
	parameter int SLOPE_FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
	// corner3_x, corner3_y (16 bits each, from bit 0 up)
	input  wire logic [127:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// center_x [17:0], center_y [35:18], zero fill [39:36]
	output logic [39:0]       m_tdata,
	// status [1:0], saturated [2]
	output logic [2:0]        m_tuser
);

	localparam int SF   = SLOPE_FRAC_BITS;
	localparam int SQW  = SF + 16;
	localparam int SW   = SF + 17;
	localparam int DENW = SW + 1;
	localparam int DMW  = DENW - 1;
	localparam int NUMW = SF + 35;
	localparam int PW   = SW + 19;

	typedef struct packed {
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] x3;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] y3;
		logic               dup;
		logic               v02;
		logic               v13;
		logic               sgn02;
	} side_t;

	typedef struct packed {
		logic                  sgn;
		logic                  big;
		logic                  dup;
		logic                  v02;
		logic                  v13;
		logic                  par;
		logic signed [SW-1:0]  my;
		logic [COORD_W-1:0]    ybase;
		logic [COORD_W-1:0]    xsub;
		logic [COORD_W-1:0]    xcv;
	} side2_t;

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Input decode.
	logic [COORD_W-1:0] cx_in [4];
	logic [COORD_W-1:0] cy_in [4];
	for (genvar i = 0; i < 4; i++) begin : g_unpack
		assign cx_in[i] = s_tdata[32*i +: 16];
		assign cy_in[i] = s_tdata[32*i+16 +: 16];
	end

	logic signed [16:0] dx02, dy02, dx13, dy13;
	logic dup_in;
	assign dx02 = $signed({1'b0, cx_in[2]}) - $signed({1'b0, cx_in[0]});
	assign dy02 = $signed({1'b0, cy_in[2]}) - $signed({1'b0, cy_in[0]});
	assign dx13 = $signed({1'b0, cx_in[3]}) - $signed({1'b0, cx_in[1]});
	assign dy13 = $signed({1'b0, cy_in[3]}) - $signed({1'b0, cy_in[1]});
	assign dup_in = ({cx_in[0], cy_in[0]} == {cx_in[1], cy_in[1]}) ||
	                ({cx_in[0], cy_in[0]} == {cx_in[2], cy_in[2]}) ||
	                ({cx_in[0], cy_in[0]} == {cx_in[3], cy_in[3]}) ||
	                ({cx_in[1], cy_in[1]} == {cx_in[2], cy_in[2]}) ||
	                ({cx_in[1], cy_in[1]} == {cx_in[3], cy_in[3]}) ||
	                ({cx_in[2], cy_in[2]} == {cx_in[3], cy_in[3]});

	// Stage 1: operands for the slope dividers.
	logic                vld_s1;
	side_t               side_s1;
	logic [COORD_W-1:0]  ady02_s1, adx02_s1, ady13_s1, adx13_s1;
	logic                sgn13_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.x0    <= cx_in[0];
			side_s1.x1    <= cx_in[1];
			side_s1.x3    <= cx_in[3];
			side_s1.y0    <= cy_in[0];
			side_s1.y3    <= cy_in[3];
			side_s1.dup   <= dup_in;
			side_s1.v02   <= (dx02 == '0);
			side_s1.v13   <= (dx13 == '0);
			side_s1.sgn02 <= dy02[16] ^ dx02[16];
			sgn13_s1      <= dy13[16] ^ dx13[16];
			ady02_s1      <= 16'(dy02[16] ? -dy02 : dy02);
			adx02_s1      <= 16'(dx02[16] ? -dx02 : dx02);
			ady13_s1      <= 16'(dy13[16] ? -dy13 : dy13);
			adx13_s1      <= 16'(dx13[16] ? -dx13 : dx13);
		end
	end

	// Slope dividers.
	logic            vld02_d, vld13_d;
	logic [SQW-1:0]  q02_d, q13_d;
	side_t           side_d;
	logic            sgn13_d;

	qdi_div #(.QW(SQW), .DW(COORD_W), .SW($bits(side_t))) u_div02 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s1),
		.dividend ({{COORD_W{1'b0}}, ady02_s1, {SF{1'b0}}}),
		.divisor  (adx02_s1),
		.side_in  (side_s1),
		.out_vld  (vld02_d),
		.quotient (q02_d),
		.side_out (side_d)
	);

	qdi_div #(.QW(SQW), .DW(COORD_W), .SW(1)) u_div13 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s1),
		.dividend ({{COORD_W{1'b0}}, ady13_s1, {SF{1'b0}}}),
		.divisor  (adx13_s1),
		.side_in  (sgn13_s1),
		.out_vld  (vld13_d),
		.quotient (q13_d),
		.side_out (sgn13_d)
	);

	// Stage 2: signed slopes.
	logic                 vld_s2;
	side_t                side_s2;
	logic signed [SW-1:0] m02_s2, m13_s2;
	logic signed [SW-1:0] q02_sg, q13_sg;
	assign q02_sg = $signed({1'b0, q02_d});
	assign q13_sg = $signed({1'b0, q13_d});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld02_d && vld13_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_d;
			m02_s2  <= side_d.sgn02 ? -q02_sg : q02_sg;
			m13_s2  <= sgn13_d ? -q13_sg : q13_sg;
		end
	end

	// Stage 3: products, slope difference and the y line selection.
	logic                    vld_s3;
	side_t                   side_s3;
	logic signed [SW+16:0]   p13_s3, p02_s3;
	logic signed [DENW-1:0]  den_s3;
	logic                    par_s3;
	logic signed [16:0]      dy03_s3;
	logic signed [SW-1:0]    my_s3;
	logic [COORD_W-1:0]      ybase_s3, xsub_s3, xcv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3  <= side_s2;
			p13_s3   <= m13_s2 * $signed({1'b0, side_s2.x3});
			p02_s3   <= m02_s2 * $signed({1'b0, side_s2.x0});
			den_s3   <= DENW'(m13_s2) - DENW'(m02_s2);
			par_s3   <= (m13_s2 == m02_s2);
			dy03_s3  <= $signed({1'b0, side_s2.y0}) - $signed({1'b0, side_s2.y3});
			// Diagonal 0-2 vertical takes y from line 1-3 anchored at corner 3.
			my_s3    <= side_s2.v02 ? m13_s2 : m02_s2;
			ybase_s3 <= side_s2.v02 ? side_s2.y3 : side_s2.y0;
			xsub_s3  <= side_s2.v02 ? side_s2.x3 : side_s2.x0;
			xcv_s3   <= side_s2.v02 ? side_s2.x0 : side_s2.x1;
		end
	end

	// Stage 4: numerator and magnitudes for the x division.
	logic                   vld_s4;
	side2_t                 sd_s4;
	logic [NUMW-1:0]        anum_s4;
	logic [DMW-1:0]         aden_s4;
	logic signed [NUMW-1:0] num_c;
	assign num_c = NUMW'(p13_s3) - NUMW'(p02_s3) + (NUMW'(dy03_s3) <<< SF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			anum_s4     <= num_c[NUMW-1] ? NUMW'(-num_c) : NUMW'(num_c);
			aden_s4     <= DMW'(den_s3[DENW-1] ? -den_s3 : den_s3);
			sd_s4.sgn   <= num_c[NUMW-1] ^ den_s3[DENW-1];
			sd_s4.big   <= 1'b0;
			sd_s4.dup   <= side_s3.dup;
			sd_s4.v02   <= side_s3.v02;
			sd_s4.v13   <= side_s3.v13;
			sd_s4.par   <= par_s3;
			sd_s4.my    <= my_s3;
			sd_s4.ybase <= ybase_s3;
			sd_s4.xsub  <= xsub_s3;
			sd_s4.xcv   <= xcv_s3;
		end
	end

	// Stage 5: a quotient of 2^18 or more is flagged to saturate.
	logic            vld_s5;
	side2_t          sd_s5;
	logic [NUMW-1:0] anum_s5;
	logic [DMW-1:0]  aden_s5;
	side2_t          sd4_c;

	always_comb begin
		sd4_c     = sd_s4;
		sd4_c.big = (anum_s4 >= {aden_s4, {CX_QW{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s5   <= sd4_c;
			anum_s5 <= anum_s4;
			aden_s5 <= aden_s4;
		end
	end

	// x divider.
	logic             vldx_d;
	logic [CX_QW-1:0] qx_d;
	side2_t           sdx_d;

	qdi_div #(.QW(CX_QW), .DW(DMW), .SW($bits(side2_t))) u_divx (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s5),
		.dividend (anum_s5),
		.divisor  (aden_s5),
		.side_in  (sd_s5),
		.out_vld  (vldx_d),
		.quotient (qx_d),
		.side_out (sdx_d)
	);

	// Stage 6: clipped x and the offset for the y line.
	logic                    vld_s6;
	side2_t                  sd_s6;
	logic signed [OUT_W-1:0] cx_s6;
	logic                    satx_s6;
	logic signed [OUT_W:0]   d_s6;
	logic signed [OUT_W-1:0] cxg_c, cx_c;
	logic                    satg_c;
	logic signed [OUT_W:0]   qneg_c;
	assign qneg_c = -$signed({1'b0, qx_d});

	always_comb begin
		satg_c = 1'b0;
		if (sdx_d.sgn) begin
			if (sdx_d.big || qx_d > MAG_NEG_MAX) begin
				cxg_c  = OUT_MIN;
				satg_c = 1'b1;
			end else begin
				cxg_c = OUT_W'(qneg_c);
			end
		end else begin
			if (sdx_d.big || qx_d > MAG_POS_MAX) begin
				cxg_c  = OUT_MAX;
				satg_c = 1'b1;
			end else begin
				cxg_c = $signed(qx_d);
			end
		end
		if (sdx_d.v02 || sdx_d.v13) begin
			cx_c = $signed({{(OUT_W-COORD_W){1'b0}}, sdx_d.xcv});
		end else begin
			cx_c = cxg_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vldx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s6   <= sdx_d;
			cx_s6   <= cx_c;
			satx_s6 <= satg_c && !(sdx_d.v02 || sdx_d.v13);
			d_s6    <= (OUT_W+1)'(cx_c) - $signed({3'b000, sdx_d.xsub});
		end
	end

	// Stage 7: slope times offset.
	logic                    vld_s7;
	side2_t                  sd_s7;
	logic signed [OUT_W-1:0] cx_s7;
	logic                    satx_s7;
	logic signed [PW-1:0]    prod_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s7   <= sd_s6;
			cx_s7   <= cx_s6;
			satx_s7 <= satx_s6;
			prod_s7 <= sd_s6.my * d_s6;
		end
	end

	// Stage 8: scale back toward zero, add the base, clip, set status.
	logic                    vld_s8;
	logic signed [OUT_W-1:0] cx_s8, cy_s8;
	status_t                 st_s8;
	logic                    sat_s8;
	logic signed [PW-1:0]    tq_c;
	logic signed [PW:0]      yv_c;
	logic signed [OUT_W-1:0] cy_c;
	logic                    saty_c;
	status_t                 st_c;

	always_comb begin
		tq_c = prod_s7 >>> SF;
		if (prod_s7[PW-1] && (prod_s7[SF-1:0] != '0)) begin
			tq_c = tq_c + PW'(1);
		end
		yv_c   = (PW+1)'(tq_c) + $signed({{(PW+1-COORD_W){1'b0}}, sd_s7.ybase});
		saty_c = 1'b0;
		if (yv_c < (PW+1)'(OUT_MIN)) begin
			cy_c   = OUT_MIN;
			saty_c = 1'b1;
		end else if (yv_c > (PW+1)'(OUT_MAX)) begin
			cy_c   = OUT_MAX;
			saty_c = 1'b1;
		end else begin
			cy_c = OUT_W'(yv_c);
		end
		if (sd_s7.dup) begin
			st_c = ST_DUP;
		end else if (sd_s7.v02 && sd_s7.v13) begin
			st_c = ST_BOTH_VERT;
		end else if (!sd_s7.v02 && !sd_s7.v13 && sd_s7.par) begin
			st_c = ST_PARALLEL;
		end else begin
			st_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s8 <= st_c;
			if (st_c == ST_OK) begin
				cx_s8  <= cx_s7;
				cy_s8  <= cy_c;
				sat_s8 <= satx_s7 || saty_c;
			end else begin
				cx_s8  <= '0;
				cy_s8  <= '0;
				sat_s8 <= 1'b0;
			end
		end
	end

	assign m_tvalid = vld_s8;
	assign m_tdata  = {4'b0000, cy_s8, cx_s8};
	assign m_tuser  = {sat_s8, st_s8};

endmodule

`default_nettype wire

[src/qdi_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a valid bit and a side word along with each item. Uses no package.
`default_nettype none

module qdi_div #(
	parameter int QW = 32,
	parameter int DW = 16,
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire logic [QW+DW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	input  wire logic [SW-1:0] side_in,
	output logic               out_vld,
	output logic [QW-1:0]      quotient,
	output logic [SW-1:0]      side_out
);

	localparam int RW = QW + DW;

	logic          vld_s  [QW];
	logic [RW-1:0] rem_s  [QW];
	logic [DW-1:0] dvs_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int SH = QW - 1 - k;
		logic          vld_in;
		logic [RW-1:0] rem_in;
		logic [DW-1:0] dvs_in;
		logic [QW-1:0] quo_in;
		logic [SW-1:0] side_i;
		logic [RW-1:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign vld_in = in_vld;
			assign rem_in = dividend;
			assign dvs_in = divisor;
			assign quo_in = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign rem_in = rem_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign quo_in = quo_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign trial = {{QW{1'b0}}, dvs_in} << SH;
		assign ge    = (rem_in >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rem_in - trial : rem_in;
				dvs_s[k]  <= dvs_in;
				quo_s[k]  <= {quo_in[QW-2:0], ge};
				side_s[k] <= side_i;
			end
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign quotient = quo_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

`default_nettype wire

[src/qdi_chk.sv]
// Port-level checker for the quadrilateral diagonal intersection block.
// Depends on qdi_pkg; bound to the top level at the end of this file.
`default_nettype none

module qdi_chk
	import qdi_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	// A held result must stay until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A stalled output stops the whole pipeline, including the input.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while output stalled");

	// Error results carry a zero point.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != ST_OK) |-> (m_tdata[35:0] == '0))
		else $error("error result with nonzero point");

	// Error results never report clipping.
	a_err_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != ST_OK) |-> !m_tuser[2])
		else $error("error result flagged saturated");

endmodule

bind quad_diagonal_intersection qdi_chk u_qdi_chk (.*);

`default_nettype wire
